[hw/rtl/dgsp_pkg.sv]
// Package for the dense graph shortest path block.
// Holds field widths, command codes, controller states and the command and status structs; no dependencies.
package dgsp_pkg;

  localparam int unsigned VTX_W  = 6;
  localparam int unsigned DIST_W = 22;
  localparam int unsigned WIN_W  = 16;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_RELAX_RD,
    ST_RELAX,
    ST_RELAX_END,
    ST_EMIT
  } dgsp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;      // write zero at the sweep index
    logic load_wr;     // write the input edge
    logic init;        // reset per-vertex state for a run
    logic scan_step;   // compare vertex at index against current pick
    logic scan_start;  // clear the pick
    logic visit;       // mark pick visited
    logic relax_rd;    // issue matrix read for pick row at index
    logic relax_step;  // relax the returned edge
    logic idx_clr;     // index back to zero
    logic idx_inc;     // index plus one
    logic emit_load;   // load output register from index
  } dgsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;    // index is at the last row/vertex
    logic clr_last;    // sweep address is at the last entry
    logic pick_valid;  // a pick exists after a scan
    logic src_ok;      // run source is in range
  } dgsp_stat_t;

endpackage

[hw/rtl/dgsp_if.sv]
// Valid/ready channel interfaces for input and result transfers.
// Depends on dgsp_pkg for field widths.
interface dgsp_in_if import dgsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [VTX_W-1:0] from_vertex;
  logic [VTX_W-1:0] to_vertex;
  logic [WIN_W-1:0] edge_weight;
  logic [VTX_W-1:0] source_vertex;
  modport source (output valid, command, from_vertex, to_vertex, edge_weight,
                  source_vertex, input ready);
  modport sink (input valid, command, from_vertex, to_vertex, edge_weight,
                source_vertex, output ready);
endinterface

interface dgsp_out_if import dgsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VTX_W-1:0]  vertex;
  logic [DIST_W-1:0] distance;
  logic [VTX_W-1:0]  predecessor;
  logic              has_predecessor;
  logic              reachable;
  logic              last;
  modport source (output valid, vertex, distance, predecessor, has_predecessor,
                  reachable, last, input ready);
  modport sink (input valid, vertex, distance, predecessor, has_predecessor,
                reachable, last, output ready);
endinterface

[hw/rtl/dgsp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dgsp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/dgsp_ctrl.sv]
// Controller state machine for the shortest path block.
// Depends on dgsp_pkg; drives datapath commands from status.
module dgsp_ctrl import dgsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic       out_valid,
  input  logic       out_ready,
  input  dgsp_stat_t stat,
  output dgsp_cmd_t  cmd
);

  dgsp_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.idx_clr    = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = stat.src_ok ? ST_SCAN : ST_EMIT;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (stat.idx_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        cmd.idx_clr = 1'b1;
        if (stat.pick_valid) begin
          cmd.visit = 1'b1;
          state_nxt = ST_RELAX_RD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_RELAX_RD: begin
        cmd.relax_rd = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = ST_RELAX;
      end
      ST_RELAX: begin
        // Read for the next column overlaps relaxing this one.
        cmd.relax_step = 1'b1;
        cmd.relax_rd   = 1'b1;
        cmd.idx_inc    = 1'b1;
        if (stat.idx_last) begin
          state_nxt = ST_RELAX_END;
        end
      end
      ST_RELAX_END: begin
        cmd.relax_step = 1'b1;
        cmd.idx_clr    = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit_load = 1'b1;
          cmd.idx_inc   = 1'b1;
          if (stat.idx_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/dgsp_dp.sv]
// Datapath: edge matrix RAM, per-vertex registers, min scan and relaxation.
// Depends on dgsp_pkg and dgsp_ram.
module dgsp_dp import dgsp_pkg::*; #(
  parameter int unsigned VERTICES    = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dgsp_cmd_t         cmd,
  output dgsp_stat_t        stat,
  input  logic [VTX_W-1:0]  in_from_vertex,
  input  logic [VTX_W-1:0]  in_to_vertex,
  input  logic [WIN_W-1:0]  in_edge_weight,
  input  logic [VTX_W-1:0]  in_source_vertex,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VTX_W-1:0]  out_vertex,
  output logic [DIST_W-1:0] out_distance,
  output logic [VTX_W-1:0]  out_predecessor,
  output logic              out_has_predecessor,
  output logic              out_reachable,
  output logic              out_last
);

  localparam int unsigned IW    = $clog2(VERTICES);
  // Rows are padded to a power of two so that {row, column} addresses every entry.
  localparam int unsigned DEPTH = VERTICES * (1 << IW);
  localparam int unsigned AW    = 2 * IW;
  localparam logic [IW-1:0] IDX_LAST = IW'(VERTICES - 1);

  logic [IW-1:0]          idx_r;
  logic [AW-1:0]          clr_addr_r;
  logic [DIST_W-1:0]      dist_r  [VERTICES];
  logic [VERTICES-1:0]    known_r;
  logic [VERTICES-1:0]    done_r;
  logic [IW-1:0]          pred_r  [VERTICES];
  logic [VERTICES-1:0]    haspred_r;
  logic [IW-1:0]          pick_r;
  logic                   pick_valid_r;
  logic [IW-1:0]          col_r;
  logic                   src_ok_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic                   load_ok;

  // Matrix write port: clearing sweep after reset or an edge load.
  assign load_ok = ({1'b0, in_from_vertex} < (VTX_W+1)'(VERTICES)) &&
                   ({1'b0, in_to_vertex} < (VTX_W+1)'(VERTICES));
  always_comb begin
    ram_we    = cmd.clr_wr || (cmd.load_wr && load_ok);
    ram_waddr = cmd.clr_wr ? clr_addr_r
                           : {in_from_vertex[IW-1:0], in_to_vertex[IW-1:0]};
    ram_wdata = cmd.clr_wr ? '0 : WEIGHT_BITS'(in_edge_weight);
  end

  dgsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr ({pick_r, idx_r}),
    .rdata (ram_rdata)
  );

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Shared vertex index.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
    end
  end

  // Relaxation candidate for the column returned by the RAM.
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sum_sat;
  logic              relax_hit;
  always_comb begin
    sum       = {1'b0, dist_r[pick_r]} + (DIST_W+1)'(ram_rdata);
    sum_sat   = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    relax_hit = (ram_rdata != '0) && !done_r[col_r] &&
                (!known_r[col_r] || (sum_sat < dist_r[col_r]));
  end

  // Scan compare of the vertex at the index against the current pick.
  logic scan_take;
  always_comb begin
    scan_take = !done_r[idx_r] && known_r[idx_r] &&
                (!pick_valid_r || (dist_r[idx_r] < dist_r[pick_r]));
  end

  // Per-vertex state and pick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r       <= '0;
      known_r      <= '0;
      haspred_r    <= '0;
      pick_valid_r <= 1'b0;
      src_ok_r     <= 1'b0;
    end else begin
      if (cmd.init) begin
        done_r    <= '0;
        known_r   <= '0;
        haspred_r <= '0;
        src_ok_r  <= ({1'b0, in_source_vertex} < (VTX_W+1)'(VERTICES));
        for (int v = 0; v < VERTICES; v++) begin
          dist_r[v] <= '0;
        end
        if ({1'b0, in_source_vertex} < (VTX_W+1)'(VERTICES)) begin
          known_r[in_source_vertex[IW-1:0]] <= 1'b1;
        end
      end
      if (cmd.scan_start) begin
        pick_valid_r <= 1'b0;
      end
      if (cmd.scan_step && scan_take) begin
        pick_r       <= idx_r;
        pick_valid_r <= 1'b1;
      end
      if (cmd.visit) begin
        done_r[pick_r] <= 1'b1;
      end
      if (cmd.relax_step && relax_hit) begin
        dist_r[col_r]    <= sum_sat;
        known_r[col_r]   <= 1'b1;
        pred_r[col_r]    <= pick_r;
        haspred_r[col_r] <= 1'b1;
      end
    end
  end

  // Column tag is registered together with the RAM read, so it matches the returned data.
  always_ff @(posedge clk) begin
    if (cmd.relax_rd) begin
      col_r <= idx_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_vertex          <= VTX_W'(idx_r);
      out_distance        <= known_r[idx_r] ? dist_r[idx_r] : '0;
      out_predecessor     <= haspred_r[idx_r] ? VTX_W'(pred_r[idx_r]) : '0;
      out_has_predecessor <= haspred_r[idx_r];
      out_reachable       <= known_r[idx_r];
      out_last            <= (idx_r == IDX_LAST);
    end
  end

  assign stat.idx_last   = (idx_r == IDX_LAST);
  assign stat.clr_last   = (clr_addr_r == AW'(DEPTH - 1));
  assign stat.pick_valid = pick_valid_r;
  assign stat.src_ok     = src_ok_r;

endmodule

[hw/rtl/dense_graph_shortest_paths.sv]
// Dense graph shortest paths: edge loads are accepted one load per cycle while idle.
// A run is accepted, then a setup step, up to VERTICES rounds of a scan, then
// relaxation through the single matrix read port, a final scan, then VERTICES
// results loaded while out_ch is ready; an out-of-range source goes straight to results.
// No input is accepted until the last result is loaded. After synchronous reset the
// matrix is cleared by a sweep of VERTICES rows of 2**clog2(VERTICES) entries, input held off.
module dense_graph_shortest_paths import dgsp_pkg::*; #(
  parameter int unsigned VERTICES    = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dgsp_in_if.sink   in_ch,
  dgsp_out_if.source out_ch
);

  dgsp_cmd_t  cmd;
  dgsp_stat_t stat;

  dgsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dgsp_dp #(.VERTICES(VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_from_vertex      (in_ch.from_vertex),
    .in_to_vertex        (in_ch.to_vertex),
    .in_edge_weight      (in_ch.edge_weight),
    .in_source_vertex    (in_ch.source_vertex),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_vertex          (out_ch.vertex),
    .out_distance        (out_ch.distance),
    .out_predecessor     (out_ch.predecessor),
    .out_has_predecessor (out_ch.has_predecessor),
    .out_reachable       (out_ch.reachable),
    .out_last            (out_ch.last)
  );

endmodule

[bench/dgsp_tb_if.sv]
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces come from the RTL file dgsp_if.sv.
// This file holds the transfer record types used by the bench; depends on dgsp_pkg.
package dgsp_tb_pkg;
  import dgsp_pkg::*;

  // One result transfer as the bench sees it.
  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [DIST_W-1:0] distance;
    logic [VTX_W-1:0]  predecessor;
    logic              has_predecessor;
    logic              reachable;
    logic              last;
  } path_result_t;

  // One input transfer.
  typedef struct packed {
    logic             command;
    logic [VTX_W-1:0] from_vertex;
    logic [VTX_W-1:0] to_vertex;
    logic [WIN_W-1:0] edge_weight;
    logic [VTX_W-1:0] source_vertex;
  } graph_cmd_t;
endpackage

[bench/dense_graph_shortest_paths_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for dense_graph_shortest_paths: loads edges, runs
// Dijkstra from many sources and checks each vertex result against a predictor.
// Depends on dgsp_pkg, dgsp_if, dgsp_tb_pkg and the block itself.
module dense_graph_shortest_paths_tb;
  import dgsp_pkg::*;
  import dgsp_tb_pkg::*;

  localparam int NV = 16;
  localparam int WB = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dgsp_in_if  in_ch ();
  dgsp_out_if out_ch ();

  dense_graph_shortest_paths #(.VERTICES(NV), .WEIGHT_BITS(WB)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Predictor state: the edge matrix as the block should hold it.
  logic [WB-1:0] weights [NV][NV];
  path_result_t  pending_paths [$];
  int mismatches = 0;
  int long_hold = 0;

  // Apply one accepted command to the predictor matrix, or predict a run.
  task automatic predict_command(input graph_cmd_t c);
    logic [DIST_W-1:0] dist_v [NV];
    bit known [NV];
    bit visited [NV];
    int prev [NV];
    int pick;
    logic [DIST_W:0] sum;
    path_result_t r;
    if (c.command == CMD_LOAD) begin
      if (c.from_vertex < NV && c.to_vertex < NV)
        weights[c.from_vertex][c.to_vertex] = c.edge_weight[WB-1:0];
      return;
    end
    for (int v = 0; v < NV; v++) begin
      dist_v[v] = '0; known[v] = 0; visited[v] = 0; prev[v] = NV;
    end
    if (c.source_vertex < NV) begin
      known[c.source_vertex] = 1;
      for (int rnd = 0; rnd < NV; rnd++) begin
        pick = -1;
        for (int v = 0; v < NV; v++)
          if (!visited[v] && known[v] && (pick < 0 || dist_v[v] < dist_v[pick]))
            pick = v;
        if (pick < 0) break;
        visited[pick] = 1;
        for (int j = 0; j < NV; j++) begin
          if (weights[pick][j] == 0 || visited[j]) continue;
          sum = dist_v[pick] + weights[pick][j];
          if (sum > DIST_MAX) sum = DIST_MAX;
          if (!known[j] || sum[DIST_W-1:0] < dist_v[j]) begin
            dist_v[j] = sum[DIST_W-1:0]; known[j] = 1; prev[j] = pick;
          end
        end
      end
    end
    for (int v = 0; v < NV; v++) begin
      r.vertex = VTX_W'(v);
      r.reachable = known[v];
      r.distance = known[v] ? dist_v[v] : '0;
      r.has_predecessor = known[v] && prev[v] < NV;
      r.predecessor = r.has_predecessor ? VTX_W'(prev[v]) : '0;
      r.last = (v == NV - 1);
      pending_paths.push_back(r);
    end
  endtask

  // Directed table: extremes, self edge, a long max-weight chain, removals, bad indexes.
  graph_cmd_t table_rows [$];
  // Hand-written expectation for a run from an out-of-range source.
  bit typed_row [$];

  function automatic graph_cmd_t mk(bit cmd, int f, int t, int w, int s);
    graph_cmd_t c;
    c.command = cmd; c.from_vertex = VTX_W'(f); c.to_vertex = VTX_W'(t);
    c.edge_weight = WIN_W'(w); c.source_vertex = VTX_W'(s);
    return c;
  endfunction

  // Build a random item: mostly in-range loads, some runs, a little noise.
  function automatic graph_cmd_t rand_cmd();
    graph_cmd_t c;
    c.command = ($urandom_range(0, 5) == 0) ? CMD_RUN : CMD_LOAD;
    c.from_vertex = ($urandom_range(0, 15) == 0) ? VTX_W'($urandom_range(0, 63))
                                                 : VTX_W'($urandom_range(0, NV - 1));
    c.to_vertex = ($urandom_range(0, 15) == 0) ? VTX_W'($urandom_range(0, 63))
                                               : VTX_W'($urandom_range(0, NV - 1));
    case ($urandom_range(0, 5))
      0: c.edge_weight = '0;
      1: c.edge_weight = 16'hFFFF;
      2: c.edge_weight = WIN_W'($urandom_range(0, 65535));
      default: c.edge_weight = WIN_W'($urandom_range(1, 40));
    endcase
    c.source_vertex = ($urandom_range(0, 9) == 0) ? VTX_W'($urandom_range(0, 63))
                                                  : VTX_W'($urandom_range(0, NV - 1));
    return c;
  endfunction

  // Offer one item and wait for its transfer; the prediction follows.
  task automatic send_item(input graph_cmd_t c, input bit typed);
    int gap;
    path_result_t r;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.command, in_ch.from_vertex, in_ch.to_vertex, in_ch.edge_weight,
     in_ch.source_vertex} <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (typed) begin
      // Out-of-range source: every vertex comes back unreachable with distance 0.
      for (int v = 0; v < NV; v++) begin
        r = '0;
        r.vertex = VTX_W'(v);
        r.last = (v == NV - 1);
        pending_paths.push_back(r);
      end
    end else begin
      predict_command(c);
    end
  endtask

  // Stimulus: directed table, then random items with one drain pause.
  initial begin
    graph_cmd_t c;
    int n;
    for (int a = 0; a < NV; a++)
      for (int b = 0; b < NV; b++) weights[a][b] = '0;
    in_ch.valid <= 1'b0;
    {in_ch.command, in_ch.from_vertex, in_ch.to_vertex, in_ch.edge_weight,
     in_ch.source_vertex} <= '0;
    table_rows.push_back(mk(1, 0, 0, 0, 0));          typed_row.push_back(0);
    table_rows.push_back(mk(1, 0, 0, 0, 63));         typed_row.push_back(1);
    table_rows.push_back(mk(0, 0, 1, 16'hFFFF, 0));   typed_row.push_back(0);
    table_rows.push_back(mk(0, 1, 2, 16'hFFFF, 0));   typed_row.push_back(0);
    for (int k = 2; k < NV - 1; k++) begin
      table_rows.push_back(mk(0, k, k + 1, 16'hFFFF, 0)); typed_row.push_back(0);
    end
    table_rows.push_back(mk(0, 5, 5, 7, 0));          typed_row.push_back(0);
    table_rows.push_back(mk(0, 63, 2, 9, 0));         typed_row.push_back(0);
    table_rows.push_back(mk(0, 2, 63, 9, 0));         typed_row.push_back(0);
    table_rows.push_back(mk(1, 0, 0, 0, 0));          typed_row.push_back(0);
    table_rows.push_back(mk(0, 3, 4, 0, 42));         typed_row.push_back(0);
    table_rows.push_back(mk(1, 63, 63, 16'hFFFF, 15)); typed_row.push_back(0);
    table_rows.push_back(mk(1, 0, 0, 0, 2));          typed_row.push_back(0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (table_rows[i]) begin
      send_item(table_rows[i], typed_row[i]);
    end
    for (n = 0; n < 250; n++) begin
      if (n == 120) begin
        // Hold off the sender until every expected result has come back.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_paths.size() != 0) @(posedge clk);
      end
      c = rand_cmd();
      send_item(c, 1'b0);
    end
    in_ch.valid <= 1'b0;
    n = 0;
    while (pending_paths.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_paths.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: random ready, with one long hold-off while items keep coming.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold == 0 && pending_paths.size() >= NV) begin
        long_hold = 1;
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result check against the oldest predicted vertex result.
  always @(posedge clk) begin
    path_result_t got;
    path_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.vertex, out_ch.distance, out_ch.predecessor,
             out_ch.has_predecessor, out_ch.reachable, out_ch.last};
      if (pending_paths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
      end else begin
        exp_r = pending_paths.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  // Watchdog against a hung block.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
